@@ src/cmdlog_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cmdlog_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int OFFSET_BITS_DEF = 40;
  localparam int OUT_OFFSET_W    = 40;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PREFIX    = 3'd1,
    ST_CRLF      = 3'd2,
    ST_TRUNC     = 3'd3,
    ST_NESTED    = 3'd4,
    ST_STRAY     = 3'd5,
    ST_OPEN      = 3'd6,
    ST_BAD_LEN   = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    PH_CNT_PREFIX = 4'd0,
    PH_CNT_S0     = 4'd1,
    PH_CNT_NEG    = 4'd2,
    PH_CNT_DIG    = 4'd3,
    PH_CNT_LF     = 4'd4,
    PH_ARG_PREFIX = 4'd5,
    PH_ARG_S0     = 4'd6,
    PH_ARG_NEG    = 4'd7,
    PH_ARG_DIG    = 4'd8,
    PH_ARG_LF     = 4'd9,
    PH_DATA       = 4'd10,
    PH_TRAIL_CR   = 4'd11,
    PH_TRAIL_LF   = 4'd12,
    PH_TRAIL_BAD  = 4'd13,
    PH_HALT       = 4'd14
  } phase_t;

  // classified byte as it travels from front to back
  typedef struct packed {
    logic [7:0] lc;
    logic [3:0] digit;
    logic       is_digit;
    logic       is_cr;
    logic       is_lf;
    logic       is_star;
    logic       is_dollar;
    logic       is_minus;
    logic       eos;
  } item_t;

  function automatic logic [7:0] kw_multi_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = "m";
      3'd1: c = "u";
      3'd2: c = "l";
      3'd3: c = "t";
      3'd4: c = "i";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] kw_exec_char(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0: c = "e";
      2'd1: c = "x";
      2'd2: c = "e";
      default: c = "c";
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ src/cmdlog_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cmdlog_front (
  input  wire logic               in_valid,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_end_of_stream,
  output logic                    in_stall,
  input  wire logic               q_full,
  output logic                    push,
  output cmdlog_pkg::item_t       push_item
);
  import cmdlog_pkg::*;

  logic [7:0] b;

  assign b        = in_data_byte;
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_item.lc        = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    push_item.is_digit  = (b >= "0" && b <= "9");
    push_item.digit     = 4'(b - "0");
    push_item.is_cr     = (b == 8'h0D);
    push_item.is_lf     = (b == 8'h0A);
    push_item.is_star   = (b == "*");
    push_item.is_dollar = (b == "$");
    push_item.is_minus  = (b == "-");
    push_item.eos       = in_end_of_stream;
  end

endmodule
`default_nettype wire

@@ src/cmdlog_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cmdlog_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire cmdlog_pkg::item_t  push_item,
  input  wire logic               pop,
  output logic                    full,
  output logic                    empty,
  output cmdlog_pkg::item_t       head
);
  import cmdlog_pkg::*;

  item_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [FIFO_PTR_W:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (FIFO_PTR_W+1)'(push) - (FIFO_PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

@@ src/cmdlog_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cmdlog_back #(
  parameter int LENGTH_BITS = cmdlog_pkg::LENGTH_BITS_DEF,
  parameter int OFFSET_BITS = cmdlog_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                q_empty,
  input  wire cmdlog_pkg::item_t                   it,
  output logic                                     pop,
  input  wire logic                                out_stall,
  output logic                                     out_valid,
  output logic [cmdlog_pkg::OUT_OFFSET_W-1:0]      out_good_offset,
  output logic [cmdlog_pkg::OUT_OFFSET_W-1:0]      out_line_number,
  output logic [2:0]                               out_status
);
  import cmdlog_pkg::*;

  localparam int SW = LENGTH_BITS + 4;
  localparam logic [SW-1:0] MAX_MAG = {5'b0, {(LENGTH_BITS-1){1'b1}}};

  phase_t                 phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt, good_r, good_nxt, line_r, line_nxt, off_inc;
  logic                   open_r, open_nxt;
  logic [LENGTH_BITS-1:0] args_r, args_nxt, bulk_r, bulk_nxt, acc_r, acc_nxt;
  logic                   neg_r, neg_nxt, first_r, first_nxt;
  logic [1:0]             kw_r, kw_nxt;
  logic [3:0]             idx_r, idx_nxt;
  status_t                err_r, err_nxt;
  logic                   ov_r, ov_nxt;
  logic [OUT_OFFSET_W-1:0] og_nxt, ol_nxt;
  status_t                os_nxt;

  logic [SW-1:0]          acc_w, sum;
  logic                   hdr_arg, hdr_s0, hdr_neg, hdr_dig;
  logic                   is_multi, is_exec, stop;

  assign pop       = !q_empty && (!ov_r || !out_stall);
  assign out_valid = ov_r;

  assign off_inc = off_r + 1'b1;
  assign acc_w   = SW'(acc_r);
  assign sum     = (acc_w << 3) + (acc_w << 1) + SW'(it.digit);

  assign hdr_arg = (phase_r == PH_ARG_S0) || (phase_r == PH_ARG_NEG) ||
                   (phase_r == PH_ARG_DIG) || (phase_r == PH_ARG_LF);
  assign hdr_s0  = (phase_r == PH_CNT_S0) || (phase_r == PH_ARG_S0);
  assign hdr_neg = (phase_r == PH_CNT_NEG) || (phase_r == PH_ARG_NEG);
  assign hdr_dig = (phase_r == PH_CNT_DIG) || (phase_r == PH_ARG_DIG);

  always_comb begin
    phase_nxt = phase_r;
    off_nxt   = off_r;
    good_nxt  = good_r;
    line_nxt  = line_r;
    open_nxt  = open_r;
    args_nxt  = args_r;
    bulk_nxt  = bulk_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    first_nxt = first_r;
    kw_nxt    = kw_r;
    idx_nxt   = idx_r;
    err_nxt   = err_r;
    ov_nxt    = ov_r && out_stall;
    og_nxt    = out_good_offset;
    ol_nxt    = out_line_number;
    os_nxt    = status_t'(out_status);
    is_multi  = 1'b0;
    is_exec   = 1'b0;
    stop      = 1'b0;

    if (pop) begin
      off_nxt = off_inc;
      unique case (phase_r)
        PH_CNT_PREFIX, PH_ARG_PREFIX: begin
          if ((phase_r == PH_CNT_PREFIX) ? it.is_star : it.is_dollar) begin
            acc_nxt   = '0;
            neg_nxt   = 1'b0;
            phase_nxt = (phase_r == PH_CNT_PREFIX) ? PH_CNT_S0 : PH_ARG_S0;
          end else begin
            err_nxt   = ST_PREFIX;
            phase_nxt = PH_HALT;
          end
        end
        PH_CNT_S0, PH_CNT_NEG, PH_CNT_DIG, PH_ARG_S0, PH_ARG_NEG, PH_ARG_DIG: begin
          if (it.is_digit) begin
            if (sum > MAX_MAG) begin
              err_nxt   = ST_BAD_LEN;
              phase_nxt = PH_HALT;
            end else begin
              acc_nxt   = LENGTH_BITS'(sum);
              phase_nxt = hdr_arg ? PH_ARG_DIG : PH_CNT_DIG;
            end
          end else if (hdr_s0 && it.is_minus) begin
            neg_nxt   = 1'b1;
            phase_nxt = hdr_arg ? PH_ARG_NEG : PH_CNT_NEG;
          end else if (!hdr_neg && it.is_cr && (hdr_s0 || hdr_dig)) begin
            phase_nxt = hdr_arg ? PH_ARG_LF : PH_CNT_LF;
          end else begin
            err_nxt   = ST_CRLF;
            phase_nxt = PH_HALT;
          end
        end
        PH_CNT_LF: begin
          if (it.is_lf) begin
            line_nxt = line_r + 1'b1;
            if (!neg_r && acc_r != '0) begin
              args_nxt  = acc_r;
              first_nxt = 1'b1;
              phase_nxt = PH_ARG_PREFIX;
            end else begin
              phase_nxt = PH_CNT_PREFIX;
              if (!open_r) good_nxt = off_inc;
            end
          end else begin
            err_nxt   = ST_CRLF;
            phase_nxt = PH_HALT;
          end
        end
        PH_ARG_LF: begin
          if (it.is_lf) begin
            line_nxt = line_r + 1'b1;
            if (neg_r && acc_r != '0) begin
              err_nxt   = ST_BAD_LEN;
              phase_nxt = PH_HALT;
            end else begin
              bulk_nxt  = acc_r;
              acc_nxt   = '0;
              idx_nxt   = '0;
              kw_nxt    = 2'b11;
              phase_nxt = (acc_r != '0) ? PH_DATA : PH_TRAIL_CR;
            end
          end else begin
            err_nxt   = ST_CRLF;
            phase_nxt = PH_HALT;
          end
        end
        PH_DATA: begin
          // bit 0: "multi" still possible, bit 1: "exec" still possible
          if (idx_r >= 4'd5 || it.lc != kw_multi_char(idx_r[2:0])) kw_nxt[0] = 1'b0;
          if (idx_r >= 4'd4 || it.lc != kw_exec_char(idx_r[1:0])) kw_nxt[1] = 1'b0;
          if (idx_r < 4'd8) idx_nxt = idx_r + 1'b1;
          bulk_nxt = bulk_r - 1'b1;
          if (bulk_nxt == '0) phase_nxt = PH_TRAIL_CR;
        end
        PH_TRAIL_CR: begin
          phase_nxt = it.is_cr ? PH_TRAIL_LF : PH_TRAIL_BAD;
        end
        PH_TRAIL_LF: begin
          if (it.is_lf) begin
            line_nxt = line_r + 1'b1;
            if (first_r) begin
              is_multi  = kw_r[0] && idx_r == 4'd5;
              is_exec   = kw_r[1] && idx_r == 4'd4;
              first_nxt = 1'b0;
              if (is_multi) begin
                if (open_r) begin
                  err_nxt = ST_NESTED;
                  stop    = 1'b1;
                end else begin
                  open_nxt = 1'b1;
                end
              end else if (is_exec) begin
                if (!open_r) begin
                  err_nxt = ST_STRAY;
                  stop    = 1'b1;
                end else begin
                  open_nxt = 1'b0;
                end
              end
            end
            if (stop) begin
              phase_nxt = PH_HALT;
            end else begin
              args_nxt = args_r - 1'b1;
              if (args_nxt == '0) begin
                phase_nxt = PH_CNT_PREFIX;
                if (!open_nxt) good_nxt = off_inc;
              end else begin
                phase_nxt = PH_ARG_PREFIX;
              end
            end
          end else begin
            err_nxt   = ST_CRLF;
            phase_nxt = PH_HALT;
          end
        end
        PH_TRAIL_BAD: begin
          err_nxt   = ST_CRLF;
          phase_nxt = PH_HALT;
        end
        default: ;
      endcase

      if (it.eos) begin
        ov_nxt = 1'b1;
        og_nxt = OUT_OFFSET_W'(good_nxt);
        ol_nxt = OUT_OFFSET_W'(line_nxt);
        if (err_nxt != ST_OK) begin
          os_nxt = err_nxt;
        end else begin
          unique case (phase_nxt)
            PH_CNT_PREFIX: os_nxt = open_nxt ? ST_OPEN : ST_OK;
            PH_ARG_PREFIX: os_nxt = open_nxt ? ST_OPEN : ST_TRUNC;
            PH_CNT_S0, PH_CNT_NEG, PH_CNT_DIG, PH_CNT_LF,
            PH_ARG_S0, PH_ARG_NEG, PH_ARG_DIG, PH_ARG_LF: os_nxt = ST_CRLF;
            default: os_nxt = ST_TRUNC;
          endcase
        end
        phase_nxt = PH_CNT_PREFIX;
        off_nxt   = '0;
        good_nxt  = '0;
        line_nxt  = OFFSET_BITS'(1);
        open_nxt  = 1'b0;
        args_nxt  = '0;
        bulk_nxt  = '0;
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
        first_nxt = 1'b0;
        kw_nxt    = 2'b11;
        idx_nxt   = '0;
        err_nxt   = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CNT_PREFIX;
      off_r   <= '0;
      good_r  <= '0;
      line_r  <= OFFSET_BITS'(1);
      open_r  <= 1'b0;
      args_r  <= '0;
      bulk_r  <= '0;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      first_r <= 1'b0;
      kw_r    <= 2'b11;
      idx_r   <= '0;
      err_r   <= ST_OK;
      ov_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      good_r  <= good_nxt;
      line_r  <= line_nxt;
      open_r  <= open_nxt;
      args_r  <= args_nxt;
      bulk_r  <= bulk_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      first_r <= first_nxt;
      kw_r    <= kw_nxt;
      idx_r   <= idx_nxt;
      err_r   <= err_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_good_offset <= og_nxt;
    out_line_number <= ol_nxt;
    out_status      <= os_nxt;
  end

endmodule
`default_nettype wire

@@ src/command_log_resp_checker_top.sv @@
// A byte accepted into the queue is parsed when the parser pops it; its result,
// if it carries end_of_stream, is registered and shows on out_valid.
// Throughput: one byte per cycle while no stalled result holds the parser; a
// four-item queue between byte classifier and parser absorbs output stalls.
// Reset (rst_n low, synchronous): parser returns to expecting '*', offsets 0,
// line count 1, queue empty, no result pending.
`timescale 1ns / 1ps
`default_nettype none
module command_log_resp_checker_top #(
  parameter int LENGTH_BITS = cmdlog_pkg::LENGTH_BITS_DEF,
  parameter int OFFSET_BITS = cmdlog_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_data_byte,
  input  wire logic                            in_end_of_stream,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [cmdlog_pkg::OUT_OFFSET_W-1:0]  out_good_offset,
  output logic [cmdlog_pkg::OUT_OFFSET_W-1:0]  out_line_number,
  output logic [2:0]                           out_status
);
  import cmdlog_pkg::*;

  logic  push, pop, q_full, q_empty;
  item_t push_item, head;

  cmdlog_front u_front (
    .in_valid        (in_valid),
    .in_data_byte    (in_data_byte),
    .in_end_of_stream(in_end_of_stream),
    .in_stall        (in_stall),
    .q_full          (q_full),
    .push            (push),
    .push_item       (push_item)
  );

  cmdlog_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  cmdlog_back #(
    .LENGTH_BITS(LENGTH_BITS),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .it             (head),
    .pop            (pop),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_good_offset(out_good_offset),
    .out_line_number(out_line_number),
    .out_status     (out_status)
  );

endmodule
`default_nettype wire

@@ src/cmdlog_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cmdlog_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [cmdlog_pkg::OUT_OFFSET_W-1:0] out_good_offset,
  input wire logic [2:0]                      out_status
);
  import cmdlog_pkg::*;

  // reset empties the queue and drops any pending result
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_good_offset) && $stable(out_status))
    else $error("result changed under stall");

endmodule

bind command_log_resp_checker_top cmdlog_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_good_offset(out_good_offset),
  .out_status     (out_status)
);
`default_nettype wire

@@ tb/cmdlog_result_checker.sv @@
`timescale 1ns / 1ps
module cmdlog_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_stream,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [39:0] out_good_offset,
  input  logic [39:0] out_line_number,
  input  logic [2:0]  out_status,
  output int          fail_count,
  output int          pending
);
  import cmdlog_pkg::*;

  localparam longint unsigned MAX_MAG = (64'd1 << 31) - 1;

  typedef struct {
    bit [39:0] good_offset;
    bit [39:0] line_number;
    status_t   status;
  } log_result_t;

  log_result_t expected_results[$];

  phase_t          phase;
  bit [39:0]       offs, good_offs, lines;
  bit              txn_open, neg, first_arg;
  longint unsigned args_left, bulk_left, acc;
  bit [1:0]        kw_alive;
  bit [2:0]        err;

  function automatic void clear_parser();
    phase     = PH_CNT_PREFIX;
    offs      = '0;
    good_offs = '0;
    lines     = 40'd1;
    txn_open  = 0;
    args_left = 0;
    bulk_left = 0;
    acc       = 0;
    neg       = 0;
    first_arg = 0;
    kw_alive  = 2'b11;
    err       = 3'd0;
  endfunction

  function automatic void halt(status_t code);
    err   = code;
    phase = PH_HALT;
  endfunction

  function automatic void command_start();
    phase = PH_CNT_PREFIX;
    if (!txn_open) good_offs = offs;
  endfunction

  function automatic void take_digit(int base, int d);
    if (acc > (MAX_MAG - d) / 10) begin
      halt(ST_BAD_LEN);
      return;
    end
    acc   = acc * 10 + d;
    phase = phase_t'(base + 2);
  endfunction

  function automatic void header_end(int base);
    lines = lines + 1;
    if (base == PH_CNT_S0) begin
      if (!neg && acc > 0) begin
        args_left = acc;
        first_arg = 1;
        phase     = PH_ARG_PREFIX;
      end else begin
        command_start();
      end
      return;
    end
    if (neg && acc > 0) begin
      halt(ST_BAD_LEN);
      return;
    end
    bulk_left = acc;
    acc       = 0;
    kw_alive  = 2'b11;
    phase     = (bulk_left != 0) ? PH_DATA : PH_TRAIL_CR;
  endfunction

  function automatic void header_char(int base, bit [7:0] b);
    int sub;
    bit dig;
    sub = int'(phase) - base;
    dig = (b >= "0" && b <= "9");
    if (sub == 0) begin
      if (b == "-") begin
        neg   = 1;
        phase = phase_t'(base + 1);
      end else if (dig) take_digit(base, b - "0");
      else if (b == 8'd13) phase = phase_t'(base + 3);
      else halt(ST_CRLF);
    end else if (sub == 1) begin
      if (dig) take_digit(base, b - "0");
      else halt(ST_CRLF);
    end else if (sub == 2) begin
      if (dig) take_digit(base, b - "0");
      else if (b == 8'd13) phase = phase_t'(base + 3);
      else halt(ST_CRLF);
    end else begin
      if (b == 8'd10) header_end(base);
      else halt(ST_CRLF);
    end
  endfunction

  function automatic void data_char(bit [7:0] b);
    string   w_multi, w_exec;
    bit [7:0] lc;
    w_multi = "multi";
    w_exec  = "exec";
    lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    if (acc >= 5 || lc != w_multi[acc]) kw_alive &= 2'b10;
    if (acc >= 4 || lc != w_exec[acc]) kw_alive &= 2'b01;
    if (acc < 8) acc = acc + 1;
    bulk_left = bulk_left - 1;
    if (bulk_left == 0) phase = PH_TRAIL_CR;
  endfunction

  function automatic void argument_end();
    bit is_multi, is_exec;
    lines = lines + 1;
    if (first_arg) begin
      is_multi  = kw_alive[0] && acc == 5;
      is_exec   = kw_alive[1] && acc == 4;
      first_arg = 0;
      if (is_multi) begin
        if (txn_open) begin
          halt(ST_NESTED);
          return;
        end
        txn_open = 1;
      end else if (is_exec) begin
        if (!txn_open) begin
          halt(ST_STRAY);
          return;
        end
        txn_open = 0;
      end
    end
    args_left = args_left - 1;
    if (args_left == 0) command_start();
    else phase = PH_ARG_PREFIX;
  endfunction

  function automatic status_t end_status();
    if (err != 0) return status_t'(err);
    if (phase == PH_CNT_PREFIX) return txn_open ? ST_OPEN : ST_OK;
    if (phase == PH_ARG_PREFIX) return txn_open ? ST_OPEN : ST_TRUNC;
    if ((phase >= PH_CNT_S0 && phase < PH_ARG_PREFIX) ||
        (phase >= PH_ARG_S0 && phase < PH_DATA)) return ST_CRLF;
    return ST_TRUNC;
  endfunction

  function automatic void parse_byte(bit [7:0] b, bit eos);
    log_result_t r;
    offs = offs + 1;
    if (phase == PH_CNT_PREFIX || phase == PH_ARG_PREFIX) begin
      if (b == ((phase == PH_CNT_PREFIX) ? "*" : "$")) begin
        acc   = 0;
        neg   = 0;
        phase = phase_t'(phase + 1);
      end else halt(ST_PREFIX);
    end else if (phase >= PH_CNT_S0 && phase < PH_ARG_PREFIX) header_char(PH_CNT_S0, b);
    else if (phase >= PH_ARG_S0 && phase < PH_DATA) header_char(PH_ARG_S0, b);
    else if (phase == PH_DATA) data_char(b);
    else if (phase == PH_TRAIL_CR) phase = (b == 8'd13) ? PH_TRAIL_LF : PH_TRAIL_BAD;
    else if (phase == PH_TRAIL_LF) begin
      if (b == 8'd10) argument_end();
      else halt(ST_CRLF);
    end else if (phase == PH_TRAIL_BAD) halt(ST_CRLF);
    if (eos) begin
      r.good_offset = good_offs;
      r.line_number = lines;
      r.status      = end_status();
      expected_results.push_back(r);
      clear_parser();
    end
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    clear_parser();
  end

  always @(posedge clk) begin
    log_result_t e;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      clear_parser();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no item pending: status %0d", out_status);
          errs++;
        end else begin
          e = expected_results.pop_front();
          if (out_good_offset !== e.good_offset) begin
            $error("good_offset: expected %0d actual %0d", e.good_offset, out_good_offset);
            errs++;
          end
          if (out_line_number !== e.line_number) begin
            $error("line_number: expected %0d actual %0d", e.line_number, out_line_number);
            errs++;
          end
          if (out_status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, out_status);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) parse_byte(in_data_byte, in_end_of_stream);
      if (errs != 0) fail_count <= fail_count + errs;
    end
    pending <= expected_results.size();
  end
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_end_of_stream = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [39:0] out_good_offset;
  logic [39:0] out_line_number;
  logic [2:0]  out_status;
  int          fail_count;
  int          pending;

  bit [7:0] strm[$];
  int       bytes_sent = 0;
  int       streams_sent = 0;
  bit       hold_req = 0;
  bit       hold_done = 0;
  bit       paused = 0;
  bit       quiet = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  command_log_resp_checker_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_end_of_stream(in_end_of_stream),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_good_offset(out_good_offset), .out_line_number(out_line_number),
    .out_status(out_status)
  );

  cmdlog_result_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_end_of_stream(in_end_of_stream),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_good_offset(out_good_offset), .out_line_number(out_line_number),
    .out_status(out_status), .fail_count(fail_count), .pending(pending)
  );

  function automatic void put(string s);
    foreach (s[i]) strm.push_back(s[i]);
  endfunction

  function automatic void crlf();
    strm.push_back(8'd13);
    strm.push_back(8'd10);
  endfunction

  function automatic void put_hdr(string pfx, string num);
    put(pfx);
    put(num);
    crlf();
  endfunction

  function automatic void put_arg(string a);
    put_hdr("$", $sformatf("%0d", a.len()));
    put(a);
    crlf();
  endfunction

  function automatic string mixed_case(string w);
    string r;
    r = w;
    foreach (r[i]) if ($urandom_range(0, 1)) r[i] = r[i] - 8'd32;
    return r;
  endfunction

  function automatic string rand_word();
    string r;
    int    n;
    case ($urandom_range(0, 5))
      0: return "multix";
      1: return "exe";
      2: return "SET";
      default: begin
        n = $urandom_range(0, 6);
        r = "";
        // raw bytes, including high values
        for (int i = 0; i < n; i++) r = {r, "x"};
        foreach (r[i]) r[i] = 8'($urandom_range(1, 255));
        return r;
      end
    endcase
  endfunction

  function automatic void put_rand_cmd();
    int nargs;
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) begin
      put_hdr("*", $urandom_range(0, 1) ? "-3" : "0");
      return;
    end
    if (k == 1) begin
      put_hdr("*", "1");
      put_hdr("$", $urandom_range(0, 1) ? "-1" : "-0");
      return;
    end
    nargs = $urandom_range(1, 3);
    put_hdr("*", $sformatf("%0d", nargs));
    if (k < 8) put_arg(mixed_case("multi"));
    else if (k < 14) put_arg(mixed_case("exec"));
    else put_arg(rand_word());
    for (int i = 1; i < nargs; i++) put_arg(rand_word());
  endfunction

  function automatic void build_random_stream();
    int n, p;
    strm.delete();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) strm.push_back(8'($urandom_range(0, 255)));
      return;
    end
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) put_rand_cmd();
    case ($urandom_range(0, 9))
      0: begin
        p = $urandom_range(0, strm.size() - 1);
        strm[p] = 8'($urandom_range(0, 255));
      end
      1: begin
        p = $urandom_range(1, strm.size());
        while (strm.size() > p) void'(strm.pop_back());
      end
      2: begin
        p = $urandom_range(0, strm.size());
        strm.insert(p, 8'($urandom_range(0, 255)));
      end
      3: strm.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
  endfunction

  task automatic send_byte(bit [7:0] b, bit eos, bit no_gap);
    int gap;
    gap = 0;
    if (!no_gap) begin
      if ($urandom_range(0, 9) < 7) gap = $urandom_range(0, 1);
      else if ($urandom_range(0, 9) < 8) gap = $urandom_range(1, 4);
      else gap = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1;
    in_data_byte     <= b;
    in_end_of_stream <= eos;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_stream();
    bit no_gap;
    no_gap = ($urandom_range(0, 3) == 0);
    quiet  = ($urandom_range(0, 4) == 0);
    if (strm.size() == 0) strm.push_back(8'($urandom_range(0, 255)));
    foreach (strm[i]) send_byte(strm[i], i == strm.size() - 1, no_gap);
    streams_sent++;
  endtask

  task automatic directed_stream(int id);
    strm.delete();
    case (id)
      0: begin
        put_hdr("*", "1"); put_arg("MULTI");
        put_hdr("*", "2"); put_arg("set"); put_arg({8'hff, 8'h00});
        put_hdr("*", "1"); put_arg("Exec");
      end
      1: begin put_hdr("*", "1"); put_arg("multi"); put_hdr("*", "1"); put_arg("multi"); end
      2: begin put_hdr("*", "1"); put_arg("exec"); end
      3: begin put_hdr("*", "1"); put_arg("mUlTi"); end
      4: begin put_hdr("*", "-1"); put_hdr("*", ""); end
      5: begin put_hdr("*", "1"); put_hdr("$", "-1"); end
      6: put("*2147483648");
      7: begin put_hdr("*", "2147483647"); put("$"); end
      8: put("*-\015");
      9: put("x");
      10: begin put_hdr("*", "1"); put("$1"); crlf(); put("aXY"); end
      11: put("*1");
      12: begin put_hdr("*", "1"); end
      13: begin put_hdr("*", "1"); put_hdr("$", "3"); put("ab"); end
      14: begin put_hdr("*", "1"); put_arg("multi"); put_hdr("*", "1"); end
      default: put("*1\015x");
    endcase
    send_stream();
  endtask

  always @(negedge clk) begin
    int run;
    if (hold_req && !hold_done) begin
      hold_done = 1;
      out_stall <= 1;
      repeat (150) @(negedge clk);
      out_stall <= 0;
    end else if (quiet) begin
      out_stall <= 0;
    end else if (run > 0) begin
      run--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall <= 1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    end else begin
      out_stall <= 0;
      run = $urandom_range(0, 8);
    end
  end

  initial begin
    int waited;
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    for (int d = 0; d < 16; d++) directed_stream(d);
    while (bytes_sent < 750) begin
      if (bytes_sent >= 400) hold_req = 1;
      if (!paused && bytes_sent >= 550) begin
        paused = 1;
        in_valid <= 0;
        while (pending != 0) @(negedge clk);
      end
      build_random_stream();
      send_stream();
    end
    in_valid <= 0;
    waited = 0;
    while (pending != 0 && waited < 10000) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #40000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

@@ filelist.f @@
src/cmdlog_pkg.sv
src/cmdlog_front.sv
src/cmdlog_fifo.sv
src/cmdlog_back.sv
src/command_log_resp_checker_top.sv
src/cmdlog_checker.sv
tb/cmdlog_result_checker.sv
tb/tb.sv
